@@ rtl/core/decimal_token_set_loader_unit_macros.svh @@
// Assertion macros shared by the token set loader RTL.
`ifndef DECIMAL_TOKEN_SET_LOADER_UNIT_MACROS_SVH
`define DECIMAL_TOKEN_SET_LOADER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTSL_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DTSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dtsl_pkg.sv @@
// Shared types and constants of the decimal token set loader.
`timescale 1ns / 1ps
package dtsl_pkg;

	localparam int unsigned DEF_CAPACITY = 512;
	localparam int unsigned VAL_W        = 32;

	// Duplicate-search probe as it walks down the chain of cells.
	typedef struct packed {
		logic live;
		logic hit;
	} probe_t;

	// Token phase codes.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_SKIP  = 2'd3;

	// Token error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_BAD   = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_BAD      = 3'd1;
	localparam logic [2:0] ST_NODIG    = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_DUP      = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_ARG_OK   = 3'd6;
	localparam logic [2:0] ST_ARG_FAIL = 3'd7;

	// Character codes.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

endpackage

@@ rtl/core/dtsl_cell.sv @@
// One cell of the value chain: a stored value and one probe stage.
`timescale 1ns / 1ps
module dtsl_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [dtsl_pkg::VAL_W-1:0]        shift_in,
	input  logic [dtsl_pkg::VAL_W-1:0]        key,
	input  logic                              inject,
	input  dtsl_pkg::probe_t                  probe_in,
	output logic [dtsl_pkg::VAL_W-1:0]        value_out,
	output dtsl_pkg::probe_t                  probe_out
);
	import dtsl_pkg::*;

	logic [VAL_W-1:0] value_q;
	probe_t           probe_q;
	logic             match;

	assign match     = (value_q == key);
	assign value_out = value_q;
	assign probe_out = probe_q;

	// An append moves every stored value one cell further from the head.
	always_ff @(posedge clk) begin
		if (push) begin
			value_q <= shift_in;
		end
	end

	// A probe starts at the oldest occupied cell and moves one cell toward the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else if (inject) begin
			probe_q.live <= 1'b1;
			probe_q.hit  <= match;
		end else begin
			probe_q.live <= probe_in.live;
			probe_q.hit  <= probe_in.live & (probe_in.hit | match);
		end
	end

endmodule

@@ rtl/core/dtsl_chain.sv @@
// Row of value cells that holds the store and runs the duplicate search.
`timescale 1ns / 1ps
module dtsl_chain #(
	parameter int unsigned CAPACITY = dtsl_pkg::DEF_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic [dtsl_pkg::VAL_W-1:0]           key,
	input  logic                                 inject,
	input  logic [$clog2(CAPACITY)-1:0]          inject_idx,
	output dtsl_pkg::probe_t                     head
);
	import dtsl_pkg::*;

	localparam int unsigned IW = $clog2(CAPACITY);

	logic [VAL_W-1:0] vals [CAPACITY];
	probe_t           probes [CAPACITY+1];

	// Nothing lies beyond the last cell.
	assign probes[CAPACITY] = '0;
	assign head             = probes[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             inj;
		logic [VAL_W-1:0] src;

		assign inj = inject && (inject_idx == IW'(i));

		if (i == 0) begin : g_head
			assign src = key;
		end else begin : g_body
			assign src = vals[i-1];
		end

		dtsl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.push      (push),
			.shift_in  (src),
			.key       (key),
			.inject    (inj),
			.probe_in  (probes[i+1]),
			.value_out (vals[i]),
			.probe_out (probes[i])
		);
	end

endmodule

@@ rtl/core/decimal_token_set_loader_unit.sv @@
// Top level of the decimal token set loader: character parser, control and value chain.
//
// Usage: one character word is taken at a rising edge where start is high and busy
// is low; arg_last marks the final character of an argument. Tokens are separated
// by spaces and hold an optional sign and decimal digits within 32-bit signed range.
// Results leave on value, status, arg_end and stored_count, each shown for exactly
// one cycle with done high; the receiver cannot stall and must take every word.
// A character that closes nothing leaves busy low.
// A failed token shows its result in the cycle after acceptance, with busy low unless it ends the argument.
// A well formed token goes through the duplicate search in the cell chain: the probe
// enters at the oldest stored value and walks one cell per cycle toward the head;
// busy stays high throughout, and with an empty store no probe is sent. The closing
// result of an argument follows in the cycle after the token result, or comes from
// the S_END state after its last character if no token closes there.
// Reset clears the token, argument and count state; store contents are not cleared,
// entries at or above the count are never searched. No clearing pass is needed.
`timescale 1ns / 1ps
`include "decimal_token_set_loader_unit_macros.svh"
module decimal_token_set_loader_unit #(
	parameter int unsigned CAPACITY = dtsl_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         ch,
	input  logic               arg_last,
	output logic               done,
	output logic signed [31:0] value,
	output logic [2:0]         status,
	output logic               arg_end,
	output logic [9:0]         stored_count
);
	import dtsl_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INJ  = 2'd1;
	localparam logic [1:0] S_SRCH = 2'd2;
	localparam logic [1:0] S_END  = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [VAL_W-1:0] mag_q;
	logic             neg_q;
	logic [1:0]       phase_q;
	logic [1:0]       err_q;
	logic             failed_q;
	logic             had_q;
	logic             last_q;
	logic [VAL_W-1:0] key_q;
	logic             done_q;
	logic [VAL_W-1:0] value_q;
	logic [2:0]       status_q;
	logic             arg_end_q;

	logic             accept;
	logic             is_digit;
	logic             is_sign;
	logic [3:0]       dig;
	logic [35:0]      nxt;
	logic [35:0]      limit;
	logic [VAL_W-1:0] mag_n;
	logic             neg_n;
	logic [1:0]       phase_n;
	logic [1:0]       err_n;
	logic             had_n;
	logic             fin;
	logic             tok_bad;
	logic [2:0]       fail_code;
	logic [VAL_W-1:0] tok_val;

	probe_t           head;
	logic             fin_now;
	logic             hit;
	logic             full;
	logic [2:0]       fin_st;
	logic             push;
	logic             inject;

	assign accept       = start && (state_q == S_IDLE);
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign value        = value_q;
	assign status       = status_q;
	assign arg_end      = arg_end_q;
	assign stored_count = 10'(count_q);

	// Character step: a token opens on its first non-space byte and closes on a
	// space or on the last byte of the argument.
	always_comb begin
		is_digit = (ch >= CH_0) && (ch <= CH_9);
		is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
		dig      = 4'(ch - CH_0);
		mag_n    = mag_q;
		neg_n    = neg_q;
		err_n    = err_q;
		phase_n  = phase_q;
		had_n    = had_q;
		fin      = 1'b0;
		nxt      = '0;
		limit    = '0;
		if (phase_q == PH_SKIP) begin
			fin = 1'b0;
		end else if (ch == CH_SPACE) begin
			fin = (phase_q != PH_IDLE);
		end else begin
			if (phase_q == PH_IDLE) begin
				mag_n   = '0;
				neg_n   = (ch == CH_MINUS);
				err_n   = ERR_NONE;
				had_n   = 1'b1;
				phase_n = PH_SIGN;
			end
			if (!((phase_q == PH_IDLE) && is_sign)) begin
				if (is_digit) begin
					nxt   = ({4'b0, mag_n} << 3) + ({4'b0, mag_n} << 1) + 36'(dig);
					limit = neg_n ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
					if (err_n == ERR_NONE) begin
						if (nxt > limit) begin
							err_n = ERR_RANGE;
						end else begin
							mag_n = nxt[VAL_W-1:0];
						end
					end
					phase_n = PH_DIGIT;
				end else begin
					err_n = ERR_BAD;
				end
			end
			fin = arg_last;
		end
	end

	assign tok_bad   = (err_n != ERR_NONE) || (phase_n == PH_SIGN);
	assign fail_code = (err_n == ERR_BAD)    ? ST_BAD   :
	                   (phase_n == PH_SIGN)  ? ST_NODIG : ST_RANGE;
	assign tok_val   = neg_n ? (VAL_W'(0) - mag_n) : mag_n;

	// Search outcome; with an empty store the token finishes without a probe.
	assign fin_now = ((state_q == S_INJ) && (count_q == '0)) ||
	                 ((state_q == S_SRCH) && head.live);
	assign hit     = (state_q == S_SRCH) && head.hit;
	assign full    = (count_q == CAP_C);
	assign fin_st  = hit ? ST_DUP : (full ? ST_FULL : ST_STORED);
	assign push    = fin_now && !hit && !full;
	assign inject  = (state_q == S_INJ) && (count_q != '0);

	dtsl_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.key        (key_q),
		.inject     (inject),
		.inject_idx (IW'(count_q - 1'b1)),
		.head       (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			phase_q  <= PH_IDLE;
			err_q    <= ERR_NONE;
			failed_q <= 1'b0;
			had_q    <= 1'b0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q) inside
				S_IDLE: begin
					if (accept) begin
						mag_q   <= mag_n;
						neg_q   <= neg_n;
						err_q   <= err_n;
						phase_q <= phase_n;
						had_q   <= had_n;
						last_q  <= arg_last;
						if (fin && !tok_bad) begin
							state_q <= S_INJ;
						end else begin
							if (fin) begin
								done_q   <= 1'b1;
								failed_q <= 1'b1;
								phase_q  <= PH_SKIP;
								mag_q    <= '0;
								neg_q    <= 1'b0;
								err_q    <= ERR_NONE;
							end
							if (arg_last) begin
								state_q <= S_END;
							end
						end
					end
				end
				S_INJ, S_SRCH: begin
					if (fin_now) begin
						done_q <= 1'b1;
						if (push) begin
							count_q <= count_q + 1'b1;
						end
						phase_q  <= (fin_st == ST_STORED) ? PH_IDLE : PH_SKIP;
						failed_q <= failed_q | (fin_st != ST_STORED);
						mag_q    <= '0;
						neg_q    <= 1'b0;
						err_q    <= ERR_NONE;
						state_q  <= last_q ? S_END : S_IDLE;
					end else if (state_q == S_INJ) begin
						state_q <= S_SRCH;
					end
				end
				S_END: begin
					done_q   <= 1'b1;
					phase_q  <= PH_IDLE;
					mag_q    <= '0;
					neg_q    <= 1'b0;
					err_q    <= ERR_NONE;
					failed_q <= 1'b0;
					had_q    <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word and search key.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= tok_val;
		end
		if (accept && fin && tok_bad) begin
			value_q   <= '0;
			status_q  <= fail_code;
			arg_end_q <= 1'b0;
		end
		if (fin_now) begin
			value_q   <= key_q;
			status_q  <= fin_st;
			arg_end_q <= 1'b0;
		end
		if (state_q == S_END) begin
			value_q   <= '0;
			status_q  <= (had_q && !failed_q) ? ST_ARG_OK : ST_ARG_FAIL;
			arg_end_q <= 1'b1;
		end
	end

	`DTSL_ASSERT(a_count_cap, clk, arst_n, 1'b1, count_q <= CAP_C, "store count above capacity")
	`DTSL_ASSERT(a_probe_in_search, clk, arst_n, head.live, state_q == S_SRCH, "probe outside search")
	`DTSL_ASSERT(a_store_grows, clk, arst_n, done_q && !arg_end_q && status_q == ST_STORED, count_q == $past(count_q) + 1'b1, "stored word without count step")
	`DTSL_ASSERT_NXT(a_last_holds_busy, clk, arst_n, start && !busy && arg_last, busy, "argument end not pending")

endmodule

@@ tb/decimal_token_set_loader_unit_tb.sv @@
// Self-checking testbench for the decimal token set loader with random argument strings.
`timescale 1ns / 1ps
module decimal_token_set_loader_unit_tb;
	import dtsl_pkg::*;

	localparam int unsigned CAP = DEF_CAPACITY;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
		logic               arg_end;
		logic [9:0]         stored_count;
	} load_result_t;

	class token_store_checker;
		logic [31:0]  store_vals[CAP];
		int unsigned  held;
		logic [31:0]  magnitude;
		logic         neg;
		logic [1:0]   phase;
		logic [1:0]   tok_err;
		logic         arg_bad;
		logic         arg_seen;
		load_result_t awaited[$];
		int           errors;
		int           words;
		int           skipped;
		int           checked;
		int           status_tally[8];

		function new();
			held = 0;
			magnitude = '0;
			neg = 1'b0;
			phase = PH_IDLE;
			tok_err = ERR_NONE;
			arg_bad = 1'b0;
			arg_seen = 1'b0;
		endfunction

		function void queue_result(logic [31:0] v, logic [2:0] st, logic e);
			load_result_t r;
			r.value = v;
			r.status = st;
			r.arg_end = e;
			r.stored_count = held[9:0];
			awaited.push_back(r);
			status_tally[st]++;
		endfunction

		function void clear_token();
			magnitude = '0;
			neg = 1'b0;
			tok_err = ERR_NONE;
		endfunction

		function void add_digit(logic [7:0] c);
			logic [63:0] nxt;
			logic [63:0] limit;
			if (c >= CH_0 && c <= CH_9) begin
				// Once over the limit the magnitude is frozen.
				if (tok_err == ERR_NONE) begin
					limit = neg ? 64'd2147483648 : 64'd2147483647;
					nxt = {32'd0, magnitude} * 64'd10 + {56'd0, c - CH_0};
					if (nxt > limit)
						tok_err = ERR_RANGE;
					else
						magnitude = nxt[31:0];
				end
				phase = PH_DIGIT;
			end else begin
				tok_err = ERR_BAD;
			end
		endfunction

		function void close_token();
			logic [2:0]  st;
			logic [31:0] v;
			v = '0;
			if (tok_err == ERR_BAD) begin
				st = ST_BAD;
			end else if (phase == PH_SIGN) begin
				st = ST_NODIG;
			end else if (tok_err == ERR_RANGE) begin
				st = ST_RANGE;
			end else begin
				v = neg ? (32'd0 - magnitude) : magnitude;
				st = ST_STORED;
				for (int i = 0; i < held; i++)
					if (store_vals[i] == v)
						st = ST_DUP;
				if (st == ST_STORED) begin
					if (held >= CAP) begin
						st = ST_FULL;
					end else begin
						store_vals[held] = v;
						held++;
					end
				end
			end
			if (st != ST_STORED) begin
				arg_bad = 1'b1;
				phase = PH_SKIP;
			end else begin
				phase = PH_IDLE;
			end
			clear_token();
			queue_result(v, st, 1'b0);
		endfunction

		function void note_word(logic [7:0] c, logic l);
			words++;
			if (phase == PH_SKIP) begin
				skipped++;
			end else if (c == CH_SPACE) begin
				if (phase != PH_IDLE)
					close_token();
			end else begin
				if (phase == PH_IDLE) begin
					clear_token();
					arg_seen = 1'b1;
					phase = PH_SIGN;
					if (c == CH_PLUS || c == CH_MINUS)
						neg = (c == CH_MINUS);
					else
						add_digit(c);
				end else begin
					add_digit(c);
				end
				if (l)
					close_token();
			end
			if (l) begin
				// The closing word resets all token and argument state, not the store.
				clear_token();
				phase = PH_IDLE;
				queue_result('0, (arg_seen && !arg_bad) ? ST_ARG_OK : ST_ARG_FAIL, 1'b1);
				arg_bad = 1'b0;
				arg_seen = 1'b0;
			end
		endfunction

		function void flag(string what, logic signed [63:0] want, logic signed [63:0] got);
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_result(load_result_t got);
			load_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result with nothing expected, expected none, got value %0d status %0d",
						$time, got.value, got.status);
				return;
			end
			want = awaited.pop_front();
			if (got.value !== want.value)
				flag("value", want.value, got.value);
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.arg_end !== want.arg_end)
				flag("arg_end", want.arg_end, got.arg_end);
			if (got.stored_count !== want.stored_count)
				flag("stored_count", want.stored_count, got.stored_count);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [7:0]         ch;
	logic               arg_last;
	logic               done;
	logic signed [31:0] value;
	logic [2:0]         status;
	logic               arg_end;
	logic [9:0]         stored_count;

	token_store_checker sb;
	logic [7:0]         arg_bytes[$];
	int                 fresh_next;
	int                 burst_left;
	int                 idle_cycles = 0;

	decimal_token_set_loader_unit #(.CAPACITY(CAP)) uut (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Results come first so that a word accepted on the same edge never meets its own result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result('{value, status, arg_end, stored_count});
			if (start && !busy)
				sb.note_word(ch, arg_last);
		end
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("decimal_token_set_loader_unit test failed");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] c, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b1;
		ch <= c;
		arg_last <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_arg();
		foreach (arg_bytes[i])
			send_word(arg_bytes[i], i == arg_bytes.size() - 1);
		arg_bytes.delete();
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			arg_bytes.push_back(s[i]);
	endfunction

	function automatic void add_token();
		int         pick;
		int         v;
		int         at;
		logic [7:0] junk;
		pick = $urandom_range(0, 99);
		if (pick < 60 || (pick < 72 && sb.held == 0)) begin
			// Fresh short values alternate in sign so that the store keeps growing.
			v = (fresh_next % 2 == 0) ? fresh_next / 2 : -((fresh_next + 1) / 2);
			fresh_next++;
			if (v < 0)
				arg_bytes.push_back(CH_MINUS);
			else if ($urandom_range(0, 4) == 0)
				arg_bytes.push_back(CH_PLUS);
			if ($urandom_range(0, 9) == 0)
				add_text("00");
			add_text($sformatf("%0d", (v < 0) ? -v : v));
		end else if (pick < 72) begin
			add_text($sformatf("%0d", $signed(sb.store_vals[$urandom_range(0, sb.held - 1)])));
		end else if (pick < 78) begin
			add_text($sformatf("%0d", $signed($urandom())));
		end else if (pick < 82) begin
			case ($urandom_range(0, 4))
				0: add_text("2147483647");
				1: add_text("-2147483648");
				2: add_text("+2147483647");
				3: add_text("-0");
				default: add_text("+0");
			endcase
		end else if (pick < 86) begin
			case ($urandom_range(0, 3))
				0: add_text("2147483648");
				1: add_text("-2147483649");
				2: add_text("+99999999999999999999");
				default: begin
					add_text($sformatf("%0d", $urandom_range(1, 9)));
					repeat ($urandom_range(10, 13))
						add_text($sformatf("%0d", $urandom_range(0, 9)));
				end
			endcase
		end else if (pick < 94) begin
			at = $urandom_range(0, 3);
			junk = 8'($urandom_range(0, 255));
			if (junk == CH_SPACE)
				junk = 8'h00;
			for (int i = 0; i < 4; i++) begin
				if (i == at)
					arg_bytes.push_back(junk);
				else
					add_text($sformatf("%0d", $urandom_range(0, 9)));
			end
		end else if (pick < 97) begin
			arg_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
		end else begin
			add_text($sformatf("%0d", $urandom_range(1, 99)));
			arg_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
			if ($urandom_range(0, 1) != 0)
				add_text($sformatf("%0d", $urandom_range(0, 9)));
		end
	endfunction

	task automatic random_arg();
		int n;
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 8))
				arg_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				add_text(" ");
			n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
			for (int k = 0; k < n; k++) begin
				if (k > 0) begin
					add_text(" ");
					if ($urandom_range(0, 4) == 0)
						add_text(" ");
				end
				add_token();
			end
			if ($urandom_range(0, 6) == 0)
				add_text(" ");
		end
		if (arg_bytes.size() == 0)
			add_text(" ");
		send_arg();
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		ch <= '0;
		arg_last <= 1'b0;
		burst_left = 0;
		fresh_next = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed arguments: single tokens, empty and bare-sign arguments, odd bytes,
		// a duplicate written as minus zero, a sign inside a token and skipping after it.
		add_text("0");
		send_arg();
		add_text(" ");
		send_arg();
		add_text("+");
		send_arg();
		add_text("-");
		send_arg();
		arg_bytes.push_back(8'h00);
		send_arg();
		arg_bytes.push_back(8'hFF);
		send_arg();
		add_text("3 ");
		send_arg();
		add_text("9 -0");
		send_arg();
		add_text("1+2");
		send_arg();
		add_text("7 x 8");
		send_arg();

		// Random arguments until about 1900 characters have gone in.
		while (sb.words < 1900)
			random_arg();
		start <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters, %0d of them inside failed arguments; checked %0d results.",
			sb.words, sb.skipped, sb.checked);
		$display("Store ended with %0d values; %0d duplicate, %0d range and %0d full-store rejections.",
			sb.held, sb.status_tally[ST_DUP], sb.status_tally[ST_RANGE], sb.status_tally[ST_FULL]);
		if (sb.errors == 0) begin
			$display("decimal_token_set_loader_unit test passed");
		end else begin
			$display("decimal_token_set_loader_unit test failed");
		end
		$finish;
	end
endmodule
